### hdl/direct_mapped_search_result_table_core_macros.svh
// assertion macros for the search result table checker
// no dependencies; included by the checker file only
`ifndef DIRECT_MAPPED_SEARCH_RESULT_TABLE_CORE_MACROS_SVH
`define DIRECT_MAPPED_SEARCH_RESULT_TABLE_CORE_MACROS_SVH

// same-cycle or delayed implication, checked outside reset
`define DMSRT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("search table check failed");

// next-cycle implication, checked outside reset
`define DMSRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("search table check failed");

`endif

### hdl/dmsrt_pkg.sv
// types and constants of the direct-mapped search result table
// no dependencies; imported by every module of the block but the memory
`default_nettype none

package dmsrt_pkg;

  localparam int unsigned DMSRT_ADDR_BITS = 10;
  localparam int unsigned KEY_W           = 64;
  localparam int unsigned SCORE_W         = 16;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned IDX_BITS_W      = 4;
  localparam int unsigned CFG_DATA_W      = 4;
  localparam logic [IDX_BITS_W-1:0] INDEX_BITS_RESET = 4'd10;

  typedef enum logic {
    FUNC_PROBE = 1'b0,
    FUNC_STORE = 1'b1
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_EXACT = 2'd0,
    KIND_LOWER = 2'd1,
    KIND_UPPER = 2'd2
  } kind_e;

  typedef enum logic {
    REG_ENABLE     = 1'b0,
    REG_INDEX_BITS = 1'b1
  } reg_e;

  typedef struct packed {
    logic                   valid;
    logic [KEY_W-1:0]       key;
    logic signed [SCORE_W-1:0] score;
    logic [KIND_W-1:0]      kind;
  } entry_t;

  typedef struct packed {
    logic                  enable;
    logic [IDX_BITS_W-1:0] index_bits;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic probe;
  } req_t;

endpackage

`default_nettype wire

### hdl/dmsrt_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module dmsrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/dmsrt_ctrl.sv
// configuration registers and the valid-clearing sweep over the slot memory
// depends on dmsrt_pkg
`default_nettype none

module dmsrt_ctrl
  import dmsrt_pkg::*;
#(
  parameter int unsigned ADDR_BITS = DMSRT_ADDR_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o,
  output logic                  clearing_o,
  output logic [ADDR_BITS-1:0]  clear_addr_o
);

  cfg_t                 cfg_q, cfg_d;
  logic                 clear_q, clear_d;
  logic [ADDR_BITS-1:0] cnt_q, cnt_d;
  logic                 wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d   = cfg_q;
    clear_d = clear_q;
    cnt_d   = cnt_q;
    if (clear_q) begin
      cnt_d = cnt_q + 1'b1;
      if (&cnt_q) begin
        clear_d = 1'b0;
      end
    end
    if (wr) begin
      case (cfg_index_i)
        REG_ENABLE: begin
          cfg_d.enable = cfg_data_i[0];
        end
        REG_INDEX_BITS: begin
          // a size change invalidates every slot
          cfg_d.index_bits = cfg_data_i[IDX_BITS_W-1:0];
          clear_d          = 1'b1;
          cnt_d            = '0;
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable     <= 1'b0;
      cfg_q.index_bits <= INDEX_BITS_RESET;
      clear_q          <= 1'b1;
      cnt_q            <= '0;
    end else begin
      cfg_q   <= cfg_d;
      clear_q <= clear_d;
      cnt_q   <= cnt_d;
    end
  end

  assign cfg_o        = cfg_q;
  assign clearing_o   = clear_q;
  assign clear_addr_o = cnt_q;

endmodule

`default_nettype wire

### hdl/dmsrt_match.sv
// probe stage: compares the slot read from memory and registers the result word
// depends on dmsrt_pkg
`default_nettype none

module dmsrt_match
  import dmsrt_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  req_t                      req_i,
  input  logic [KEY_W-1:0]          key_i,
  input  logic signed [SCORE_W-1:0] alpha_i,
  input  logic signed [SCORE_W-1:0] beta_i,
  input  entry_t                    entry_i,
  output logic                      result_valid_o,
  output logic                      hit_o,
  output logic signed [SCORE_W-1:0] found_score_o
);

  logic                      acc_q, probe_q, res_valid_q;
  logic [KEY_W-1:0]          key_q;
  logic signed [SCORE_W-1:0] alpha_q, beta_q;
  logic                      hit_q, hit_d;
  logic signed [SCORE_W-1:0] score_q, score_d;
  logic                      bound_ok;

  always_comb begin
    case (entry_i.kind)
      KIND_EXACT: bound_ok = 1'b1;
      KIND_LOWER: bound_ok = entry_i.score >= beta_q;
      KIND_UPPER: bound_ok = entry_i.score <= alpha_q;
      default:    bound_ok = 1'b0;
    endcase
    hit_d   = probe_q && entry_i.valid && (entry_i.key == key_q) && bound_ok;
    score_d = hit_d ? entry_i.score : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= 1'b0;
      probe_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      acc_q       <= req_i.accept;
      probe_q     <= req_i.probe;
      res_valid_q <= acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_i;
    alpha_q <= alpha_i;
    beta_q  <= beta_i;
    hit_q   <= hit_d;
    score_q <= score_d;
  end

  assign result_valid_o = res_valid_q;
  assign hit_o          = hit_q;
  assign found_score_o  = score_q;

endmodule

`default_nettype wire

### hdl/direct_mapped_search_result_table_core.sv
// result: an accepted word's strobe passes the accept register, then the result-valid register
// throughput: one probe or store per cycle while busy is low; stores write at the accept edge
// reset: valid marks cleared by a sweep over all 2^ADDR_BITS slots with busy high;
// an index_bits write starts the same sweep; the receiver cannot stall
`default_nettype none

module direct_mapped_search_result_table_core
  import dmsrt_pkg::*;
#(
  parameter int unsigned ADDR_BITS = DMSRT_ADDR_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      func_i,
  input  logic [KEY_W-1:0]          position_key_i,
  input  logic signed [SCORE_W-1:0] window_low_i,
  input  logic signed [SCORE_W-1:0] window_high_i,
  input  logic signed [SCORE_W-1:0] store_score_i,
  input  logic [KIND_W-1:0]         bound_kind_i,
  output logic                      result_valid_o,
  output logic                      hit_o,
  output logic signed [SCORE_W-1:0] found_score_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned DEPTH = 2 ** ADDR_BITS;

  cfg_t                 cfg;
  logic                 clearing;
  logic [ADDR_BITS-1:0] clear_addr;
  logic [ADDR_BITS-1:0] slot;
  logic                 accept;
  req_t                 req;
  logic                 we;
  logic [ADDR_BITS-1:0] waddr;
  entry_t               wentry;
  entry_t               rentry;

  dmsrt_ctrl #(
    .ADDR_BITS(ADDR_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .clearing_o  (clearing),
    .clear_addr_o(clear_addr)
  );

  assign busy   = clearing;
  assign accept = start && !busy;

  // index bits beyond the memory size act as the full size
  always_comb begin
    for (int i = 0; i < ADDR_BITS; i++) begin
      slot[i] = position_key_i[i] && (int'(cfg.index_bits) > i);
    end
  end

  assign req.accept = accept;
  assign req.probe  = accept && cfg.enable && (func_i == FUNC_PROBE);

  always_comb begin
    wentry.valid = 1'b1;
    wentry.key   = position_key_i;
    wentry.score = store_score_i;
    wentry.kind  = bound_kind_i;
    if (clearing) begin
      wentry = '0;
    end
  end

  assign we    = clearing || (accept && cfg.enable && (func_i == FUNC_STORE));
  assign waddr = clearing ? clear_addr : slot;

  dmsrt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wentry),
    .raddr_i(slot),
    .rdata_o(rentry)
  );

  dmsrt_match u_match (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .key_i         (position_key_i),
    .alpha_i       (window_low_i),
    .beta_i        (window_high_i),
    .entry_i       (rentry),
    .result_valid_o(result_valid_o),
    .hit_o         (hit_o),
    .found_score_o (found_score_o)
  );

endmodule

`default_nettype wire

### hdl/dmsrt_checker.sv
// port-level checks of the search result table, bound to the top level
// depends on dmsrt_pkg and the macros header
`default_nettype none

`include "direct_mapped_search_result_table_core_macros.svh"

module dmsrt_checker
  import dmsrt_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      func_i,
  input  logic                      result_valid_o,
  input  logic                      hit_o,
  input  logic signed [SCORE_W-1:0] found_score_o,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_o,
  input  logic                      cfg_index_i
);

  // every accepted word gets its result strobe
  `DMSRT_ASSERT_IMPL(a_result_follows, clk_i, rst_ni, start && !busy, ##2 result_valid_o)

  // and no result appears without an accepted word
  `DMSRT_ASSERT_IMPL(a_no_spurious, clk_i, rst_ni, result_valid_o, $past(start && !busy, 2))

  // a store never reports a hit
  `DMSRT_ASSERT_IMPL(a_store_miss, clk_i, rst_ni, start && !busy && func_i == FUNC_STORE, ##2 !hit_o)

  // a miss carries a zero score
  `DMSRT_ASSERT_IMPL(a_miss_zero, clk_i, rst_ni, result_valid_o && !hit_o, found_score_o == '0)

  // a size write starts the clearing sweep
  `DMSRT_ASSERT_NEXT(a_resize_busy, clk_i, rst_ni, cfg_valid_i && cfg_ready_o && cfg_index_i == REG_INDEX_BITS, busy)

endmodule

bind direct_mapped_search_result_table_core dmsrt_checker u_checker (.*);

`default_nettype wire
